>>> hw/rtl/setlc_pkg.sv
// Shared types and constants for the sorted extent table link counter.
// Used by the search/insert engine and the top level; no dependencies.
package setlc_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // Field widths
    localparam int PART_W      = 16;
    localparam int BLOCK_W     = 32;
    localparam int LEN_W       = 30;
    localparam int KEY_W       = PART_W + BLOCK_W;
    localparam int LINK_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int OUT_IDX_W   = 10;
    localparam int ENTRY_W     = LINK_W + KEY_W;

    // Stream packing widths
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 32;

    localparam logic [LINK_W-1:0] LINK_MAX = {LINK_W{1'b1}};

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_IGNORED  = 2'd0,
        STATUS_FOUND    = 2'd1,
        STATUS_INSERTED = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    // Request handed from the input stage to the engine
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             link;
        logic             zero_len;
    } req_t;

    // Result handed from the engine to the output stage
    typedef struct packed {
        status_t              status;
        logic [OUT_IDX_W-1:0] index;
        logic [LINK_W-1:0]    link_total;
    } res_t;

endpackage

>>> hw/rtl/setlc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module setlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/setlc_engine.sv
// Search and insert sequencer: binary search, then update, shift or place.
// Depends on setlc_pkg and drives one setlc_ram holding {link, key} entries.
module setlc_engine
    import setlc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res,
    output logic               ram_we,
    output logic [IDX_W-1:0]   ram_waddr,
    output logic [ENTRY_W-1:0] ram_wdata,
    output logic               ram_re,
    output logic [IDX_W-1:0]   ram_raddr,
    input  logic [ENTRY_W-1:0] ram_rdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_PROBE_WAIT,
        ST_CHECK_WAIT,
        ST_SHIFT,
        ST_PLACE,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic [CNT_W-1:0]   sptr_reg, sptr_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               link_reg, link_next;
    res_t               res_reg, res_next;

    logic [KEY_W-1:0]   rd_key;
    logic [LINK_W-1:0]  rd_link;
    logic [CNT_W-1:0]   mid_calc;
    logic [CNT_W-1:0]   last_idx;
    logic [LINK_W-1:0]  link_bumped;
    logic               hit;

    assign rd_key   = ram_rdata[KEY_W-1:0];
    assign rd_link  = ram_rdata[ENTRY_W-1:KEY_W];
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign last_idx = count_reg - CNT_W'(1);
    assign hit      = (lo_reg < count_reg) && (rd_key == key_reg);

    // Saturating link increment
    assign link_bumped = (link_reg && rd_link != LINK_MAX) ? rd_link + LINK_W'(1) : rd_link;

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // Sequencer next state and memory control
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        sptr_next  = sptr_reg;
        key_next   = key_reg;
        link_next  = link_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    key_next  = req.key;
                    link_next = req.link;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    if (req.zero_len) begin
                        res_next   = '{status: STATUS_IGNORED, index: '0, link_total: '0};
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_PROBE;
                    end
                end
            end

            ST_PROBE: begin
                if (lo_reg < hi_reg) begin
                    ram_re     = 1'b1;
                    ram_raddr  = mid_calc[IDX_W-1:0];
                    mid_next   = mid_calc;
                    state_next = ST_PROBE_WAIT;
                end else begin
                    // Fetch the lower-bound entry for the match check
                    ram_re     = (lo_reg < count_reg);
                    ram_raddr  = lo_reg[IDX_W-1:0];
                    state_next = ST_CHECK_WAIT;
                end
            end

            ST_PROBE_WAIT: begin
                if (rd_key < key_reg) begin
                    lo_next = mid_reg + CNT_W'(1);
                end else begin
                    hi_next = mid_reg;
                end
                state_next = ST_PROBE;
            end

            ST_CHECK_WAIT: begin
                if (hit) begin
                    ram_we     = 1'b1;
                    ram_waddr  = lo_reg[IDX_W-1:0];
                    ram_wdata  = {link_bumped, rd_key};
                    res_next   = '{status: STATUS_FOUND, index: OUT_IDX_W'(lo_reg),
                                   link_total: link_bumped};
                    state_next = ST_DONE;
                end else if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                    res_next   = '{status: STATUS_FULL, index: '0, link_total: '0};
                    state_next = ST_DONE;
                end else if (lo_reg == count_reg) begin
                    state_next = ST_PLACE;
                end else begin
                    // Start moving entries up from the top end
                    ram_re     = 1'b1;
                    ram_raddr  = last_idx[IDX_W-1:0];
                    sptr_next  = last_idx;
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(sptr_reg + CNT_W'(1));
                ram_wdata = ram_rdata;
                if (sptr_reg == lo_reg) begin
                    state_next = ST_PLACE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = IDX_W'(sptr_reg - CNT_W'(1));
                    sptr_next  = sptr_reg - CNT_W'(1);
                end
            end

            ST_PLACE: begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg[IDX_W-1:0];
                ram_wdata  = {LINK_W'(link_reg), key_reg};
                count_next = count_reg + CNT_W'(1);
                res_next   = '{status: STATUS_INSERTED, index: OUT_IDX_W'(lo_reg),
                               link_total: LINK_W'(link_reg)};
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, counters and the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        sptr_reg <= sptr_next;
        key_reg  <= key_next;
        link_reg <= link_next;
        res_reg  <= res_next;
    end

endmodule

>>> hw/rtl/sorted_extent_table_link_counter.sv
// Top level of the sorted extent table link counter: stream ports, input and
// output registers. Depends on setlc_pkg, setlc_ram and setlc_engine.
//
// Each request looks up the key {partition, block_address} in a table of up
// to TABLE_DEPTH extents kept in ascending key order in one RAM. A zero-length
// request returns without a search. Any other request runs a binary search,
// each step a read (PROBE) and a compare (PROBE_WAIT); a new key then
// shifts the entries above its place up by one, one entry a cycle, and then
// writes itself into the freed place. The worst case is an insert at the front
// of a table of 1023 entries. The next request is taken into the input
// register while the engine works, and a finished result waits in the output
// register.
module sorted_extent_table_link_counter
    import setlc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // partition [15:0], block_address [47:16], extent_length [77:48], zero [79:78]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // counts_link [0]
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // entry_index [9:0], link_total [25:10], zero [31:26]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0]  m_axis_tuser
);

    logic               in_full_reg;
    req_t               in_req_reg;
    logic               out_valid_reg;
    res_t               out_res_reg;

    logic               eng_req_ready;
    logic               eng_res_valid;
    logic               eng_res_ready;
    res_t               eng_res;
    req_t               s_req;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // Unpack the incoming request
    assign s_req.key      = {s_axis_tdata[PART_W-1:0], s_axis_tdata[KEY_W-1:PART_W]};
    assign s_req.link     = s_axis_tuser;
    assign s_req.zero_len = (s_axis_tdata[KEY_W+LEN_W-1:KEY_W] == '0);

    assign s_axis_tready = !in_full_reg || eng_req_ready;
    assign eng_res_ready = !out_valid_reg || m_axis_tready;

    // Hold one request ahead of the engine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_full_reg <= 1'b1;
        end else if (eng_req_ready) begin
            in_full_reg <= 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            in_req_reg <= s_req;
        end
    end

    // Hold the finished result until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (eng_res_ready) begin
            out_valid_reg <= eng_res_valid;
        end
        if (eng_res_valid && eng_res_ready) begin
            out_res_reg <= eng_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - OUT_IDX_W - LINK_W){1'b0}},
                            out_res_reg.link_total, out_res_reg.index};
    assign m_axis_tuser  = out_res_reg.status;

    setlc_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (in_full_reg),
        .req_ready (eng_req_ready),
        .req       (in_req_reg),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    setlc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
